FILE: sv/pphc_pkg.sv
// ---------------------------------------------------------------------------
// pphc_pkg
// Shared types, constants and the CORDIC arctangent table for the controller.
// ---------------------------------------------------------------------------
`default_nettype none
package pphc_pkg;

    localparam int ANG_W = 40;  // Q.24 angle plus headroom
    localparam int VEC_W = 56;  // CORDIC vector width
    localparam int MAX_STEPS = 32;

    localparam logic signed [ANG_W-1:0] ANG_PI      = 40'sd52707179;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 40'sd105414357;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 40'sd26353589;

    typedef enum logic [1:0] {
        REG_PATH_COEF  = 2'd0,
        REG_SPEED_GAIN = 2'd1,
        REG_HEAD_GAIN  = 2'd2,
        REG_PATH_GAIN  = 2'd3
    } t_reg_idx;

    // Pose transaction
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_pose;

    // Command transaction
    typedef struct packed {
        logic [30:0]        lateral_error;
        logic signed [15:0] desired_heading;
        logic signed [15:0] heading_error;
        logic signed [15:0] linear_velocity;
        logic signed [15:0] angular_velocity;
    } t_cmd;

    // Register write transaction
    typedef struct packed {
        t_reg_idx    idx;
        logic [15:0] value;
    } t_cfg;

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [ANG_W-1:0] t_ang;

    // One CORDIC vector in flight.
    typedef struct packed {
        t_vec vx;
        t_vec vy;
        t_ang z;
    } t_cordic;

    function automatic t_ang atan_entry(input logic [4:0] i);
        t_ang r;
        r = '0;
        unique case (i)
            5'd0: r = 40'sd13176795;  5'd1: r = 40'sd7778716;
            5'd2: r = 40'sd4110060;   5'd3: r = 40'sd2086331;
            5'd4: r = 40'sd1047214;   5'd5: r = 40'sd524117;
            5'd6: r = 40'sd262123;    5'd7: r = 40'sd131069;
            5'd8: r = 40'sd65536;     5'd9: r = 40'sd32768;
            5'd10: r = 40'sd16384;    5'd11: r = 40'sd8192;
            5'd12: r = 40'sd4096;     5'd13: r = 40'sd2048;
            5'd14: r = 40'sd1024;     5'd15: r = 40'sd512;
            5'd16: r = 40'sd256;      5'd17: r = 40'sd128;
            5'd18: r = 40'sd64;       5'd19: r = 40'sd32;
            5'd20: r = 40'sd16;       5'd21: r = 40'sd8;
            5'd22: r = 40'sd4;        5'd23: r = 40'sd2;
            5'd24: r = 40'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/pphc_if.sv
// ---------------------------------------------------------------------------
// pphc_if
// Valid/ready channel interface with parameterized payload type.
// ---------------------------------------------------------------------------
`default_nettype none
interface pphc_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/parabola_path_heading_controller_top.sv
// ---------------------------------------------------------------------------
// parabola_path_heading_controller_top
// Pose controller following y = a*x^2 with CORDIC arctangents.
// ---------------------------------------------------------------------------
// Accepts one pose per cycle while the output is not stalled. Each pose passes 3
// input stages (products, then vector setup), CORDIC_STEPS cells of two parallel
// CORDIC rows, and 3 output stages (wrap, gain products, round/saturate). The
// whole pipeline advances together when the output register is empty or being
// taken, so back-pressure stalls it in place.
`default_nettype none
module parabola_path_heading_controller_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pphc_if.sink      i_pose,
    pphc_if.source    o_cmd,
    pphc_if.sink      i_cfg
);
    import pphc_pkg::*;

    localparam int DEPTH = CORDIC_STEPS + 6;

    logic signed [15:0] r_coef, r_krho, r_kalpha, r_kbeta;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef   <= 16'sd256;
            r_krho   <= 16'sd256;
            r_kalpha <= 16'sd256;
            r_kbeta  <= 16'sd0;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.data.idx))
                REG_PATH_COEF:  r_coef   <= i_cfg.data.value;
                REG_SPEED_GAIN: r_krho   <= i_cfg.data.value;
                REG_HEAD_GAIN:  r_kalpha <= i_cfg.data.value;
                REG_PATH_GAIN:  r_kbeta  <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    logic adv;
    logic [DEPTH-1:0] r_vld;
    assign adv = !r_vld[DEPTH-1] || o_cmd.ready;
    assign i_pose.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_pose.valid};
        end
    end

    // Stage 1: raw products
    logic [31:0] r1_ax, r1_ay;
    logic [15:0] r1_aa;
    logic signed [47:0] r1_slope;
    logic signed [32:0] r1_wz, r1_xy, r1_yy, r1_zz;
    logic signed [31:0] px, py;
    always_comb begin
        px = i_pose.data.pos_x;
        py = i_pose.data.pos_y;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_ax    <= px[31] ? 32'(-px) : 32'(px);
            r1_ay    <= py[31] ? 32'(-py) : 32'(py);
            r1_aa    <= r_coef[15] ? 16'(-r_coef) : 16'(r_coef);
            r1_slope <= 48'(r_coef * px);
            r1_wz    <= 33'(i_pose.data.quat_w * i_pose.data.quat_z);
            r1_xy    <= 33'(i_pose.data.quat_x * i_pose.data.quat_y);
            r1_yy    <= 33'(i_pose.data.quat_y * i_pose.data.quat_y);
            r1_zz    <= 33'(i_pose.data.quat_z * i_pose.data.quat_z);
        end
    end

    // Stage 2: x^2, yaw numerator/denominator
    logic [47:0] r2_sq;
    logic [31:0] r2_ay;
    logic [15:0] r2_aa;
    logic signed [47:0] r2_slope;
    logic signed [35:0] r2_num, r2_den;
    logic [63:0] sq_full;
    assign sq_full = r1_ax * r1_ax;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_sq    <= sq_full[63:16];
            r2_ay    <= r1_ay;
            r2_aa    <= r1_aa;
            r2_slope <= r1_slope;
            r2_num   <= 36'(2 * (36'(r1_wz) + 36'(r1_xy)));
            r2_den   <= 36'sd268435456 - 36'(2 * (36'(r1_yy) + 36'(r1_zz)));
        end
    end

    // Stage 3: desired y, diff, CORDIC setup
    logic [30:0] r3_lat;
    t_cordic r3_b, r3_y, n3_b, n3_y;
    logic [63:0] des;
    logic [47:0] diff;
    always_comb begin
        des  = 64'(r2_sq) * 64'(r2_aa);
        diff = (48'(r2_ay) > des[55:8]) ? 48'(r2_ay) - des[55:8]
                                         : des[55:8] - 48'(r2_ay);
        n3_b.vx = t_vec'(64'sd16777216);
        n3_b.vy = t_vec'(r2_slope) <<< 1;
        n3_b.z  = '0;
        if (r2_den < 0) begin
            if (r2_num >= 0) begin
                n3_y.vx = t_vec'(r2_num);
                n3_y.vy = -t_vec'(r2_den);
                n3_y.z  = ANG_HALF_PI;
            end else begin
                n3_y.vx = -t_vec'(r2_num);
                n3_y.vy = t_vec'(r2_den);
                n3_y.z  = -ANG_HALF_PI;
            end
        end else begin
            n3_y.vx = t_vec'(r2_den);
            n3_y.vy = t_vec'(r2_num);
            n3_y.z  = '0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_lat <= (des[63:56] != '0 || diff[47:31] != '0) ? '1 : diff[30:0];
            r3_b   <= n3_b;
            r3_y   <= n3_y;
        end
    end

    t_cordic cb_q, cy_q;
    pphc_chain #(.STEPS(CORDIC_STEPS)) u_beta (
        .i_clk(i_clk), .i_en(adv), .i_d(r3_b), .o_q(cb_q));
    pphc_chain #(.STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk(i_clk), .i_en(adv), .i_d(r3_y), .o_q(cy_q));

    // lateral error travels alongside the CORDIC rows
    logic [30:0] r_lat_dly [CORDIC_STEPS];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lat_dly[0] <= r3_lat;
            for (int k = 1; k < CORDIC_STEPS; k++) r_lat_dly[k] <= r_lat_dly[k-1];
        end
    end

    // Stage 4: wrap and round
    t_ang beta, alpha_raw, alpha;
    t_ang b_rnd, a_rnd;
    logic signed [15:0] r4_b13, r4_a13;
    logic [30:0] r4_lat;
    always_comb begin
        beta      = -cb_q.z;
        alpha_raw = -beta - cy_q.z;
        if (alpha_raw > ANG_PI) alpha = alpha_raw - ANG_TWO_PI;
        else if (alpha_raw < -ANG_PI) alpha = alpha_raw + ANG_TWO_PI;
        else alpha = alpha_raw;
        b_rnd = (beta + 40'sd1024) >>> 11;
        a_rnd = (alpha + 40'sd1024) >>> 11;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_b13 <= b_rnd[15:0];
            r4_a13 <= a_rnd[15:0];
            r4_lat <= r_lat_dly[CORDIC_STEPS-1];
        end
    end

    // Stage 5: gain products
    logic signed [31:0] r5_pa, r5_pb;
    logic signed [15:0] r5_b13, r5_a13;
    logic [30:0] r5_lat;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_pa  <= r_kalpha * r4_a13;
            r5_pb  <= r_kbeta * r4_b13;
            r5_b13 <= r4_b13;
            r5_a13 <= r4_a13;
            r5_lat <= r4_lat;
        end
    end

    // Stage 6: round and saturate into the output register
    logic signed [32:0] sum, om;
    logic signed [15:0] om_sat;
    always_comb begin
        sum = 33'(r5_pa) + 33'(r5_pb) + 33'sd4096;
        om  = sum >>> 13;
        if (om > 33'sd32767) om_sat = 16'sd32767;
        else if (om < -33'sd32768) om_sat = -16'sd32768;
        else om_sat = om[15:0];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_cmd.data.lateral_error    <= r5_lat;
            o_cmd.data.desired_heading  <= r5_b13;
            o_cmd.data.heading_error    <= r5_a13;
            o_cmd.data.linear_velocity  <= r_krho;
            o_cmd.data.angular_velocity <= om_sat;
        end
    end
    assign o_cmd.valid = r_vld[DEPTH-1];

`ifndef ASSERT_OFF
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pose.valid && i_pose.ready) |=> r_vld[0])
        else $error("accepted pose not tracked");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.valid && !o_cmd.ready) |=> $stable(r_vld))
        else $error("pipeline moved during stall");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cmd.valid |-> i_pose.ready)
        else $error("not ready with empty output");
`endif
endmodule
`default_nettype wire

FILE: sv/pphc_cell.sv
// ---------------------------------------------------------------------------
// pphc_cell
// One CORDIC vectoring iteration with a fixed shift, registered.
// ---------------------------------------------------------------------------
`default_nettype none
module pphc_cell #(
    parameter int STEP = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire pphc_pkg::t_cordic  i_d,
    output pphc_pkg::t_cordic       o_q
);
    import pphc_pkg::*;

    t_cordic r_q;
    t_cordic n_q;
    t_vec    dx;
    t_vec    dy;

    always_comb begin
        dx = i_d.vy >>> STEP;
        dy = i_d.vx >>> STEP;
        if (i_d.vy > 0) begin
            n_q.vx = i_d.vx + dx;
            n_q.vy = i_d.vy - dy;
            n_q.z  = i_d.z + atan_entry(5'(STEP));
        end else begin
            n_q.vx = i_d.vx - dx;
            n_q.vy = i_d.vy + dy;
            n_q.z  = i_d.z - atan_entry(5'(STEP));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

FILE: sv/pphc_chain.sv
// ---------------------------------------------------------------------------
// pphc_chain
// Row of CORDIC cells; the angle accumulates as vectors pass down the row.
// ---------------------------------------------------------------------------
`default_nettype none
module pphc_chain #(
    parameter int STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire pphc_pkg::t_cordic  i_d,
    output pphc_pkg::t_cordic       o_q
);
    import pphc_pkg::*;

    t_cordic link [STEPS+1];

    assign link[0] = i_d;

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        pphc_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (link[g]),
            .o_q   (link[g+1])
        );
    end

    assign o_q = link[STEPS];
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the parabola path heading controller.
// Drives poses through bursty valid/ready traffic, predicts every command
// from its own fixed-point model of the path, CORDIC and gain math, and
// compares each returned command field by field. Registers are rewritten
// between phases while the pipeline is drained.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;
    import pphc_pkg::*;

    localparam int STEPS    = 16;
    localparam int LATENCY  = STEPS + 6;
    localparam int N_PHASES = 7;
    localparam int N_RANDOM = 240;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pphc_if #(.T(t_pose)) pose_ch ();
    pphc_if #(.T(t_cmd))  cmd_ch ();
    pphc_if #(.T(t_cfg))  cfg_ch ();

    parabola_path_heading_controller_top #(.CORDIC_STEPS(STEPS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pose  (pose_ch.sink),
        .o_cmd   (cmd_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow registers
    logic signed [15:0] path_coef, speed_gain, head_gain, path_gain;

    t_pose pending_poses[$];
    t_cmd  expected_cmds[$];
    int    n_errors = 0;
    int    n_cmds = 0;
    int    n_poses = 0;
    int    n_cfg_writes = 0;

    longint atan_q24[STEPS] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                                262123, 131069, 65536, 32768, 16384, 8192, 4096,
                                2048, 1024, 512};

    function automatic longint vector_angle(longint vx, longint vy, longint z0);
        longint z, dx, dy;
        z = z0;
        for (int i = 0; i < STEPS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0) begin
                vx += dx; vy -= dy; z += atan_q24[i];
            end else begin
                vx -= dx; vy += dy; z -= atan_q24[i];
            end
        end
        return z;
    endfunction

    function automatic t_cmd predict_cmd(t_pose p);
        t_cmd c;
        longint px, py, a, num, den, yaw, beta, alpha, b13, a13, omega;
        longint unsigned ax, ay, aa, sq, target, diff;
        px = p.pos_x;
        py = p.pos_y;
        a  = path_coef;
        ax = (px < 0) ? -px : px;
        ay = (py < 0) ? -py : py;
        aa = (a < 0) ? -a : a;
        sq = (ax * ax) >> 16;
        target = (sq * aa) >> 8;
        diff = (ay > target) ? ay - target : target - ay;
        if (diff > 64'h7FFF_FFFF) diff = 64'h7FFF_FFFF;

        beta = -vector_angle(64'sd1 << 24, 2 * a * px, 0);

        num = 2 * (longint'(p.quat_w) * p.quat_z + longint'(p.quat_x) * p.quat_y);
        den = (64'sd1 << 28) - 2 * (longint'(p.quat_y) * p.quat_y
                                    + longint'(p.quat_z) * p.quat_z);
        if (den < 0) begin
            if (num >= 0) yaw = vector_angle(num, -den, longint'(ANG_HALF_PI));
            else          yaw = vector_angle(-num, den, -longint'(ANG_HALF_PI));
        end else begin
            yaw = vector_angle(den, num, 0);
        end

        alpha = -beta - yaw;
        if (alpha > longint'(ANG_PI)) alpha -= longint'(ANG_TWO_PI);
        else if (alpha < -longint'(ANG_PI)) alpha += longint'(ANG_TWO_PI);

        b13 = (beta + 1024) >>> 11;
        a13 = (alpha + 1024) >>> 11;
        omega = (longint'(head_gain) * a13 + longint'(path_gain) * b13 + 4096) >>> 13;
        if (omega > 32767) omega = 32767;
        if (omega < -32768) omega = -32768;

        c.lateral_error    = diff[30:0];
        c.desired_heading  = b13[15:0];
        c.heading_error    = a13[15:0];
        c.linear_velocity  = speed_gain;
        c.angular_velocity = omega[15:0];
        return c;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        n_errors++;
        $display("mismatch on command %0d: %s got %0d expected %0d",
                 n_cmds, field, got, want);
    endtask

    // register shadow follows accepted config transactions
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            n_cfg_writes++;
            case (cfg_ch.data.idx)
                REG_PATH_COEF:  path_coef  <= cfg_ch.data.value;
                REG_SPEED_GAIN: speed_gain <= cfg_ch.data.value;
                REG_HEAD_GAIN:  head_gain  <= cfg_ch.data.value;
                REG_PATH_GAIN:  path_gain  <= cfg_ch.data.value;
                default: ;
            endcase
        end
    end

    // pose driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pose_ch.valid <= 1'b0;
            pose_ch.data  <= '0;
        end else begin
            if (pose_ch.valid && pose_ch.ready) begin
                expected_cmds.push_back(predict_cmd(pose_ch.data));
                n_poses++;
            end
            if (!pose_ch.valid || pose_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    pose_ch.valid <= 1'b0;
                end else if (pending_poses.size() > 0) begin
                    pose_ch.data  <= pending_poses.pop_front();
                    pose_ch.valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    pose_ch.valid <= 1'b0;
                end
            end
        end
    end

    // command receiver: stall mode changes every so often
    int stall_mode = 0;
    int mode_cycles = 0;
    logic [7:0] stall_mask = 8'b1011_0110;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.ready <= 1'b0;
        end else begin
            if (mode_cycles == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_cycles = $urandom_range(20, 200);
                stall_mask = 8'($urandom);
            end
            mode_cycles--;
            case (stall_mode)
                0: cmd_ch.ready <= 1'b1;
                1: cmd_ch.ready <= ($urandom_range(0, 9) < 7);
                2: begin
                    cmd_ch.ready <= stall_mask[0];
                    stall_mask = {stall_mask[0], stall_mask[7:1]};
                end
                default: cmd_ch.ready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_cmd want, got;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            got = cmd_ch.data;
            if (expected_cmds.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                want = expected_cmds.pop_front();
                if (got.lateral_error !== want.lateral_error)
                    report_mismatch("lateral_error", got.lateral_error, want.lateral_error);
                if (got.desired_heading !== want.desired_heading)
                    report_mismatch("desired_heading", got.desired_heading,
                                    want.desired_heading);
                if (got.heading_error !== want.heading_error)
                    report_mismatch("heading_error", got.heading_error, want.heading_error);
                if (got.linear_velocity !== want.linear_velocity)
                    report_mismatch("linear_velocity", got.linear_velocity,
                                    want.linear_velocity);
                if (got.angular_velocity !== want.angular_velocity)
                    report_mismatch("angular_velocity", got.angular_velocity,
                                    want.angular_velocity);
            end
            n_cmds++;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [15:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{idx: idx, value: value};
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_poses.size() > 0 || pose_ch.valid || expected_cmds.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic t_pose make_pose(longint x, longint y, int qx, int qy, int qz, int qw);
        t_pose p;
        p.pos_x = 32'(x); p.pos_y = 32'(y);
        p.quat_x = 16'(qx); p.quat_y = 16'(qy); p.quat_z = 16'(qz); p.quat_w = 16'(qw);
        return p;
    endfunction

    function automatic t_pose random_pose();
        t_pose p;
        int sel;
        sel = $urandom_range(0, 9);
        p = {$urandom, $urandom, $urandom, $urandom};
        if (sel < 7) begin
            // plausible poses near the path, unit-ish quaternion
            p.pos_x = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            p.pos_y = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            p.quat_x = 16'($signed($urandom_range(0, 32768)) - 16384);
            p.quat_y = 16'($signed($urandom_range(0, 32768)) - 16384);
            p.quat_z = 16'($signed($urandom_range(0, 32768)) - 16384);
            p.quat_w = 16'($signed($urandom_range(0, 32768)) - 16384);
            if (sel < 3) begin
                // yaw-only rotation
                p.quat_x = 16'sd0;
                p.quat_y = 16'sd0;
            end
        end
        return p;
    endfunction

    logic [15:0] phase_regs[N_PHASES][4] = '{
        '{16'd256, 16'd256, 16'd256, 16'd0},
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000},
        '{16'd0, 16'd0, 16'd0, 16'd0},
        '{16'hFF00, 16'd128, 16'd1024, 16'hFE00},
        '{16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd0, 16'd0, 16'd0, 16'd0}
    };

    initial begin
        path_coef = 16'sd256; speed_gain = 16'sd256;
        head_gain = 16'sd256; path_gain = 16'sd0;
        pose_ch.valid = 1'b0;
        pose_ch.data  = '0;
        cmd_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        for (int ph = 5; ph < N_PHASES; ph++)
            for (int r = 0; r < 4; r++) phase_regs[ph][r] = 16'($urandom);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed poses at reset settings
        pending_poses.push_back(make_pose(0, 0, 0, 0, 0, 0));
        pending_poses.push_back(make_pose(0, 0, 0, 0, 0, 16384));
        pending_poses.push_back(make_pose(0, 0, 0, 0, 16384, 0));      // yaw of +pi
        pending_poses.push_back(make_pose(0, 0, 0, 0, -16384, 0));
        pending_poses.push_back(make_pose(0, 0, 0, 0, 11585, 11585));
        pending_poses.push_back(make_pose(0, 0, 0, 0, -11585, 11585));
        pending_poses.push_back(make_pose(0, 0, 16384, 16384, 0, 0));
        pending_poses.push_back(make_pose(0, 0, -32768, -32768, -32768, -32768));
        pending_poses.push_back(make_pose(0, 0, 32767, 32767, 32767, 32767));
        pending_poses.push_back(make_pose(0, 0, 100, 0, 0, 3));        // unnormalized
        pending_poses.push_back(make_pose(32'sh7FFF_FFFF, 0, 0, 0, 0, 16384));
        pending_poses.push_back(make_pose(-32'sh8000_0000, 0, 0, 0, 0, 16384));
        pending_poses.push_back(make_pose(0, 32'sh7FFF_FFFF, 0, 0, 0, 16384));
        pending_poses.push_back(make_pose(0, -32'sh8000_0000, 0, 0, 0, 16384));
        pending_poses.push_back(make_pose(32'sh0001_0000, 32'sh0001_0000, 0, 0, 0, 16384));
        pending_poses.push_back(make_pose(-32'sh0002_0000, 32'sh0004_0000, 0, 0, 16384, 0));
        pending_poses.push_back(make_pose(32'sh7FFF_FFFF, -32'sh8000_0000,
                                          -32768, 32767, -32768, 32767));
        pending_poses.push_back(make_pose(32'sh0000_8000, -32'sh0001_0000, 0, 0, -1, -16384));
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            if (ph > 0)
                for (int r = 0; r < 4; r++) write_reg(t_reg_idx'(r), phase_regs[ph][r]);
            if (ph == 1) begin
                // saturating lateral error with the largest coefficient
                pending_poses.push_back(make_pose(32'sh7FFF_FFFF, 0, 0, 0, 0, 16384));
                pending_poses.push_back(make_pose(-32'sh8000_0000, 32'sh7FFF_FFFF,
                                                  0, 0, 16384, 0));
            end
            for (int i = 0; i < N_RANDOM; i++) pending_poses.push_back(random_pose());
        end
        wait_drained();
        $display("covered %0d poses and %0d commands over %0d register settings",
                 n_poses, n_cmds, N_PHASES);
        $display("%0d register writes, %0d mismatches", n_cfg_writes, n_errors);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout: %0d commands still expected", expected_cmds.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
sv/pphc_pkg.sv
sv/pphc_if.sv
sv/pphc_cell.sv
sv/pphc_chain.sv
sv/parabola_path_heading_controller_top.sv
dv/tb_top.sv
